@@ src/ccdt_pkg.sv @@
// ----------------------------------------------------------------------------
// ccdt_pkg
// shared widths, register indexes and fixed-point constants of the
// countercurrent distribution tube unit
// ----------------------------------------------------------------------------
`default_nettype none

package ccdt_pkg;

  // q0.32 fractions held with one integer bit, so 1.0 fits
  localparam int unsigned VAL_W   = 33;
  localparam int unsigned FRAC_W  = 32;
  localparam int unsigned HALF_W  = 16;
  localparam int unsigned BH_W    = VAL_W - HALF_W;
  localparam int unsigned MUL_W   = VAL_W + BH_W;

  // divider: 48-bit dividend, 17-bit divisor
  localparam int unsigned DIV_W   = 48;
  localparam int unsigned DEN_W   = 17;
  localparam int unsigned DCNT_W  = $clog2(DIV_W);

  // field and register widths
  localparam int unsigned COEF_W  = 16;
  localparam int unsigned CYC_W   = 7;
  localparam int unsigned NCOMP_W = 3;
  localparam int unsigned TUBE_W  = 6;
  localparam int unsigned SUM_W   = 3;
  localparam int unsigned CFG_AW  = 3;
  localparam int unsigned CFG_DW  = 16;

  // register indexes
  localparam logic [CFG_AW-1:0] REG_CYCLES        = 3'd0;
  localparam logic [CFG_AW-1:0] REG_NUM_COMPOUNDS = 3'd1;
  localparam logic [CFG_AW-1:0] REG_COEFF_A       = 3'd2;
  localparam logic [CFG_AW-1:0] REG_COEFF_B       = 3'd3;
  localparam logic [CFG_AW-1:0] REG_COEFF_C       = 3'd4;
  localparam logic [CFG_AW-1:0] REG_COEFF_D       = 3'd5;

  // reset values
  localparam logic [CYC_W-1:0]   RST_CYCLES        = 7'd10;
  localparam logic [NCOMP_W-1:0] RST_NUM_COMPOUNDS = 3'd1;
  localparam logic [COEF_W-1:0]  COEF_ONE          = 16'd256;

  // fixed-point constants
  localparam logic [VAL_W-1:0] ONE_Q32 = 33'h1_0000_0000;
  localparam logic [DIV_W-1:0] Q_NUM   = 48'h0100_0000_0000;

  typedef logic [VAL_W-1:0] val_t;

endpackage

`default_nettype wire

@@ src/ccdt_div.sv @@
// ----------------------------------------------------------------------------
// ccdt_div
// restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module ccdt_div (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       start_i,
  input  wire logic [ccdt_pkg::DIV_W-1:0] dividend_i,
  input  wire logic [ccdt_pkg::DEN_W-1:0] divisor_i,
  output logic                            done_o,
  output logic [ccdt_pkg::DIV_W-1:0]      quotient_o
);
  import ccdt_pkg::*;

  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [DCNT_W-1:0] cnt_q, cnt_d;
  logic [DIV_W-1:0]  quo_q, quo_d;
  logic [DEN_W-1:0]  rem_q, rem_d;
  logic [DEN_W-1:0]  den_q, den_d;
  logic [DEN_W:0]    trial;
  logic [DEN_W:0]    diff;
  logic              ge;

  assign trial = {rem_q, quo_q[DIV_W-1]};
  assign ge    = trial >= {1'b0, den_q};
  assign diff  = trial - {1'b0, den_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    den_d  = den_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      quo_d  = dividend_i;
      rem_d  = '0;
      den_d  = divisor_i;
    end else if (busy_q) begin
      quo_d = {quo_q[DIV_W-2:0], ge};
      rem_d = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == DCNT_W'(DIV_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    den_q <= den_d;
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

`default_nettype wire

@@ src/ccdt_mul.sv @@
// ----------------------------------------------------------------------------
// ccdt_mul
// q0.32 product floor(a*b/2^32) in two passes over one 33x17 multiplier
// ----------------------------------------------------------------------------
`default_nettype none

module ccdt_mul (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           start_i,
  input  wire ccdt_pkg::val_t a_i,
  input  wire ccdt_pkg::val_t b_i,
  output logic                done_o,
  output ccdt_pkg::val_t      res_o
);
  import ccdt_pkg::*;

  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_LOW  = 2'd1;
  localparam logic [1:0] PH_HIGH = 2'd2;

  logic [1:0]        ph_q, ph_d;
  logic              done_q, done_d;
  val_t              a_q, a_d;
  logic [BH_W-1:0]   bh_q, bh_d;
  logic [HALF_W-1:0] bl_q, bl_d;
  val_t              t_q, t_d;
  val_t              res_q, res_d;
  logic [BH_W-1:0]   op;
  logic [MUL_W-1:0]  prod;
  logic [MUL_W-1:0]  acc;

  // low half of b first, then high half plus carried partial
  assign op   = (ph_q == PH_LOW) ? {1'b0, bl_q} : bh_q;
  assign prod = MUL_W'(a_q) * MUL_W'(op);
  assign acc  = prod + MUL_W'(t_q);

  always_comb begin
    ph_d   = ph_q;
    done_d = 1'b0;
    a_d    = a_q;
    bh_d   = bh_q;
    bl_d   = bl_q;
    t_d    = t_q;
    res_d  = res_q;
    unique case (ph_q)
      PH_IDLE: begin
        if (start_i) begin
          a_d  = a_i;
          bh_d = b_i[VAL_W-1:HALF_W];
          bl_d = b_i[HALF_W-1:0];
          ph_d = PH_LOW;
        end
      end
      PH_LOW: begin
        t_d  = VAL_W'(prod >> HALF_W);
        ph_d = PH_HIGH;
      end
      PH_HIGH: begin
        res_d  = VAL_W'(acc >> HALF_W);
        done_d = 1'b1;
        ph_d   = PH_IDLE;
      end
      default: ph_d = PH_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q   <= PH_IDLE;
      done_q <= 1'b0;
    end else begin
      ph_q   <= ph_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q   <= a_d;
    bh_q  <= bh_d;
    bl_q  <= bl_d;
    t_q   <= t_d;
    res_q <= res_d;
  end

  assign done_o = done_q;
  assign res_o  = res_q;

endmodule

`default_nettype wire

@@ src/countercurrent_distribution_tube_unit.sv @@
// ----------------------------------------------------------------------------
// countercurrent_distribution_tube_unit
// rounded countercurrent distribution content of one tube, summed over
// up to four compounds
// ----------------------------------------------------------------------------
// one word in gives one word out. for each configured compound the unit
// divides out p = K/(K+1) and q = 1/(K+1) in q0.32 on a bit-serial divider
// (48 quotient bits each), then steps the tube vector through cycles 1..n
// (n = cycle register minus one) in a tube memory, each tube update above
// tube 0 taking two passes through the shared two-pass multiplier and tube 0
// one; the compound adds 1 when its tube holds at least one half. words
// where the cycle register is 0, the tube lies beyond the last cycle or no
// compound is configured skip the arithmetic and finish with a sum of 0.
// the unit takes one word at a time; a finished result waits in the output
// register while the next word is taken. no clearing pass is needed after
// reset.
// ----------------------------------------------------------------------------
`default_nettype none

module countercurrent_distribution_tube_unit #(
  parameter int unsigned MAX_TUBES     = 64,
  parameter int unsigned MAX_COMPOUNDS = 4
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  // configuration write port
  input  wire logic                        cfg_we_i,
  input  wire logic [ccdt_pkg::CFG_AW-1:0] cfg_addr_i,
  input  wire logic [ccdt_pkg::CFG_DW-1:0] cfg_wdata_i,
  // input words
  input  wire logic                        s_axis_tvalid_i,
  output logic                             s_axis_tready_o,
  input  wire logic [7:0]                  s_axis_tdata_i,  // tube_number[5:0]
  // result words
  output logic                             m_axis_tvalid_o,
  input  wire logic                        m_axis_tready_i,
  output logic [15:0]                      m_axis_tdata_o   // tube_echo[5:0], rounded_sum[8:6]
);
  import ccdt_pkg::*;

  localparam int unsigned AW = (MAX_TUBES > 1) ? $clog2(MAX_TUBES) : 1;
  localparam logic [8:0]         TUBE_LIM = 9'(MAX_TUBES);
  localparam logic [NCOMP_W-1:0] COMP_LIM = NCOMP_W'(MAX_COMPOUNDS);

  // sequencer states
  localparam logic [3:0] ST_IDLE    = 4'd0;
  localparam logic [3:0] ST_PDIV_GO = 4'd1;
  localparam logic [3:0] ST_PDIV_WT = 4'd2;
  localparam logic [3:0] ST_QDIV_GO = 4'd3;
  localparam logic [3:0] ST_QDIV_WT = 4'd4;
  localparam logic [3:0] ST_INIT    = 4'd5;
  localparam logic [3:0] ST_CYC     = 4'd6;
  localparam logic [3:0] ST_CUR     = 4'd7;
  localparam logic [3:0] ST_LOOP    = 4'd8;
  localparam logic [3:0] ST_MQ      = 4'd9;
  localparam logic [3:0] ST_MP      = 4'd10;
  localparam logic [3:0] ST_RD      = 4'd11;
  localparam logic [3:0] ST_ACC     = 4'd12;
  localparam logic [3:0] ST_FIN     = 4'd13;

  // configuration registers
  logic [CYC_W-1:0]   cyc_total_q;
  logic [NCOMP_W-1:0] num_compounds_q;
  logic [COEF_W-1:0]  coeff_q [4];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cyc_total_q     <= RST_CYCLES;
      num_compounds_q <= RST_NUM_COMPOUNDS;
      coeff_q[0]      <= COEF_ONE;
      coeff_q[1]      <= COEF_ONE;
      coeff_q[2]      <= COEF_ONE;
      coeff_q[3]      <= COEF_ONE;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        REG_CYCLES:        cyc_total_q     <= cfg_wdata_i[CYC_W-1:0];
        REG_NUM_COMPOUNDS: num_compounds_q <= cfg_wdata_i[NCOMP_W-1:0];
        REG_COEFF_A:       coeff_q[0]      <= cfg_wdata_i;
        REG_COEFF_B:       coeff_q[1]      <= cfg_wdata_i;
        REG_COEFF_C:       coeff_q[2]      <= cfg_wdata_i;
        REG_COEFF_D:       coeff_q[3]      <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // sequencer state and working registers
  logic [3:0]         state_q, state_d;
  logic [TUBE_W-1:0]  tube_q, tube_d;
  logic [CYC_W-1:0]   n_q, n_d;          // last cycle index
  logic [CYC_W-1:0]   c_q, c_d;          // current cycle
  logic [NCOMP_W-1:0] count_q, count_d;  // compounds to sum
  logic [NCOMP_W-1:0] comp_q, comp_d;    // current compound
  logic [SUM_W-1:0]   sum_q, sum_d;
  logic [AW-1:0]      j_q, j_d;          // tube being updated
  val_t               p_q, p_d;
  val_t               q_q, q_d;
  val_t               cur_q, cur_d;      // old v[j]
  val_t               prev_q, prev_d;    // old v[j-1]
  val_t               acc_q, acc_d;      // v[j]*q partial

  // output register
  logic               m_valid_q, m_valid_d;
  logic [TUBE_W-1:0]  out_tube_q, out_tube_d;
  logic [SUM_W-1:0]   out_sum_q, out_sum_d;

  // tube memory
  val_t               tube_mem [MAX_TUBES];
  logic               mem_we;
  logic               mem_re;
  logic [AW-1:0]      mem_waddr;
  logic [AW-1:0]      mem_raddr;
  val_t               mem_wdata;
  val_t               mem_rdata_q;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      tube_mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      mem_rdata_q <= tube_mem[mem_raddr];
    end
  end

  // shared divider and multiplier
  logic                div_start;
  logic                div_done;
  logic [DIV_W-1:0]    div_dividend;
  logic [DEN_W-1:0]    div_divisor;
  logic [DIV_W-1:0]    div_quo;
  logic                mul_start;
  logic                mul_done;
  val_t                mul_a;
  val_t                mul_b;
  val_t                mul_res;
  logic [COEF_W-1:0]   coef_sel;

  assign coef_sel     = coeff_q[comp_q[1:0]];
  assign div_divisor  = DEN_W'(coef_sel) + DEN_W'(COEF_ONE);
  assign div_dividend = (state_q == ST_PDIV_GO) ? {coef_sel, {FRAC_W{1'b0}}} : Q_NUM;
  assign mul_a        = (state_q == ST_MQ) ? mem_rdata_q : cur_q;
  assign mul_b        = (state_q == ST_MQ) ? p_q : q_q;

  ccdt_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  ccdt_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .done_o  (mul_done),
    .res_o   (mul_res)
  );

  // helpers for the accept decision
  logic               in_take;
  logic [TUBE_W-1:0]  in_tube;
  logic [NCOMP_W-1:0] in_count;
  logic               in_empty;
  logic               out_load;

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign in_take  = s_axis_tvalid_i && s_axis_tready_o;
  assign in_tube  = s_axis_tdata_i[TUBE_W-1:0];
  assign in_count = (num_compounds_q > COMP_LIM) ? COMP_LIM : num_compounds_q;
  // no cycles, no compounds, tube past storage or past the last cycle
  assign in_empty = (cyc_total_q == '0) || (in_count == '0)
                 || ({3'b000, in_tube} >= TUBE_LIM)
                 || ({1'b0, in_tube} >= cyc_total_q);

  always_comb begin
    state_d   = state_q;
    tube_d    = tube_q;
    n_d       = n_q;
    c_d       = c_q;
    count_d   = count_q;
    comp_d    = comp_q;
    sum_d     = sum_q;
    j_d       = j_q;
    p_d       = p_q;
    q_d       = q_q;
    cur_d     = cur_q;
    prev_d    = prev_q;
    acc_d     = acc_q;
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_waddr = j_q;
    mem_raddr = j_q;
    mem_wdata = mul_res;
    div_start = 1'b0;
    mul_start = 1'b0;
    out_load  = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (in_take) begin
          tube_d  = in_tube;
          n_d     = cyc_total_q - 1'b1;
          count_d = in_count;
          comp_d  = '0;
          sum_d   = '0;
          state_d = in_empty ? ST_FIN : ST_PDIV_GO;
        end
      end
      ST_PDIV_GO: begin
        div_start = 1'b1;
        state_d   = ST_PDIV_WT;
      end
      ST_PDIV_WT: begin
        if (div_done) begin
          p_d     = VAL_W'(div_quo);
          state_d = ST_QDIV_GO;
        end
      end
      ST_QDIV_GO: begin
        div_start = 1'b1;
        state_d   = ST_QDIV_WT;
      end
      ST_QDIV_WT: begin
        if (div_done) begin
          q_d     = VAL_W'(div_quo);
          state_d = ST_INIT;
        end
      end
      ST_INIT: begin
        // cycle 0: all of the compound sits in tube 0
        mem_we    = 1'b1;
        mem_waddr = '0;
        mem_wdata = ONE_Q32;
        c_d       = CYC_W'(1);
        state_d   = ST_CYC;
      end
      ST_CYC: begin
        if (c_q > n_q) begin
          state_d = ST_RD;
        end else if (c_q <= {1'b0, tube_q}) begin
          // top tube of this cycle was empty before it
          cur_d   = '0;
          j_d     = AW'(c_q);
          state_d = ST_LOOP;
        end else begin
          mem_re    = 1'b1;
          mem_raddr = AW'(tube_q);
          j_d       = AW'(tube_q);
          state_d   = ST_CUR;
        end
      end
      ST_CUR: begin
        cur_d   = mem_rdata_q;
        state_d = ST_LOOP;
      end
      ST_LOOP: begin
        // v[j]*q first, fetch v[j-1] meanwhile
        mul_start = 1'b1;
        if (j_q != '0) begin
          mem_re    = 1'b1;
          mem_raddr = j_q - 1'b1;
        end
        state_d = ST_MQ;
      end
      ST_MQ: begin
        if (mul_done) begin
          if (j_q == '0) begin
            mem_we    = 1'b1;
            mem_waddr = '0;
            mem_wdata = mul_res;
            c_d       = c_q + 1'b1;
            state_d   = ST_CYC;
          end else begin
            acc_d     = mul_res;
            prev_d    = mem_rdata_q;
            mul_start = 1'b1;
            state_d   = ST_MP;
          end
        end
      end
      ST_MP: begin
        if (mul_done) begin
          mem_we    = 1'b1;
          mem_waddr = j_q;
          mem_wdata = acc_q + mul_res;
          cur_d     = prev_q;
          j_d       = j_q - 1'b1;
          state_d   = ST_LOOP;
        end
      end
      ST_RD: begin
        mem_re    = 1'b1;
        mem_raddr = AW'(tube_q);
        state_d   = ST_ACC;
      end
      ST_ACC: begin
        // round half up: at least 2^31
        sum_d  = sum_q + SUM_W'(mem_rdata_q[VAL_W-1] | mem_rdata_q[VAL_W-2]);
        comp_d = comp_q + 1'b1;
        state_d = (comp_d == count_q) ? ST_FIN : ST_PDIV_GO;
      end
      ST_FIN: begin
        if (!m_valid_q || m_axis_tready_i) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    m_valid_d  = m_valid_q && !m_axis_tready_i;
    out_tube_d = out_tube_q;
    out_sum_d  = out_sum_q;
    if (out_load) begin
      m_valid_d  = 1'b1;
      out_tube_d = tube_q;
      out_sum_d  = sum_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      m_valid_q <= 1'b0;
      comp_q    <= '0;
      count_q   <= '0;
      c_q       <= '0;
      j_q       <= '0;
    end else begin
      state_q   <= state_d;
      m_valid_q <= m_valid_d;
      comp_q    <= comp_d;
      count_q   <= count_d;
      c_q       <= c_d;
      j_q       <= j_d;
    end
  end

  always_ff @(posedge clk_i) begin
    tube_q     <= tube_d;
    n_q        <= n_d;
    sum_q      <= sum_d;
    p_q        <= p_d;
    q_q        <= q_d;
    cur_q      <= cur_d;
    prev_q     <= prev_d;
    acc_q      <= acc_d;
    out_tube_q <= out_tube_d;
    out_sum_q  <= out_sum_d;
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = {7'b0000000, out_sum_q, out_tube_q};

  // busy for the whole item once a word is taken
  a_busy_after_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid_i && s_axis_tready_o) |=> !s_axis_tready_o)
    else $error("ready raised right after a word was taken");

  // a compound is only counted while compounds remain
  a_comp_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_ACC) |-> (comp_q < count_q))
    else $error("compound index past configured count");

  // the tube update never writes above the tube asked for
  a_write_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> ({{(9 - AW){1'b0}}, mem_waddr} <= {3'b000, tube_q}))
    else $error("tube memory written above requested tube");

  // a result never counts more than the compounds summed
  a_sum_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> (sum_q <= count_q))
    else $error("rounded sum exceeds compound count");

endmodule

`default_nettype wire

@@ tb/countercurrent_distribution_tube_unit_test.sv @@
// ----------------------------------------------------------------------------
// countercurrent_distribution_tube_unit_test
// self-checking bench for the countercurrent distribution tube unit
// ----------------------------------------------------------------------------
// a short table of hand-picked words (reset values, no cycles, no or too
// many compounds, zero and huge coefficients, the widest and longest runs)
// is followed by random phases with their own register settings and an
// idling pattern that rotates. words with no typed-in sum are predicted in
// q0.32 fixed point; result words are compared in order, field by field.
// ----------------------------------------------------------------------------

module countercurrent_distribution_tube_unit_test;

  timeunit 1ns;
  timeprecision 1ps;

  import ccdt_pkg::*;

  // addresses outside the register map, written to show they change nothing
  localparam logic [CFG_AW-1:0] REG_UNMAPPED_A = 3'd6;
  localparam logic [CFG_AW-1:0] REG_UNMAPPED_B = 3'd7;

  localparam int unsigned COMPOUND_SLOTS = 4;
  localparam int unsigned TUBE_SLOTS     = 64;
  localparam logic [63:0] Q32_ONE        = 64'h1_0000_0000;
  localparam logic [63:0] Q32_HALF       = 64'h0_8000_0000;

  localparam int unsigned RESET_CYCLES   = 8;
  localparam int unsigned HOLD_CYCLES    = 3000;     // long receiver hold-off
  localparam int unsigned DRAIN_CYCLES   = 100;
  localparam int unsigned STALL_LIMIT    = 250000;   // cycles with no handshake
  localparam int unsigned RANDOM_PHASES  = 16;
  localparam int unsigned PHASE_WORDS    = 40;
  localparam int unsigned SLOW_WORDS     = 6;
  localparam int unsigned WIDE_PHASE     = 5;
  localparam int unsigned LONG_PHASE     = 11;
  localparam int unsigned DIRECTED_ROWS  = 25;

  typedef enum logic [1:0] {
    IDLE_NONE,
    IDLE_SENDER,
    IDLE_RECEIVER,
    IDLE_BOTH
  } idle_mode_e;

  typedef enum logic [1:0] {
    KIND_TYPICAL,
    KIND_WIDE,
    KIND_LONG
  } setting_kind_e;

  typedef struct packed {
    logic [CYC_W-1:0]   cycles;
    logic [NCOMP_W-1:0] compounds;
    logic [COEF_W-1:0]  coeff_a;
    logic [COEF_W-1:0]  coeff_b;
    logic [COEF_W-1:0]  coeff_c;
    logic [COEF_W-1:0]  coeff_d;
  } tube_setting_t;

  typedef struct packed {
    logic [TUBE_W-1:0] tube;
    logic [SUM_W-1:0]  sum;
  } tube_reading_t;

  typedef struct packed {
    tube_setting_t     setting;
    logic [TUBE_W-1:0] tube;
    logic              known;   // sum typed in below rather than predicted
    logic [SUM_W-1:0]  sum;
  } directed_row_t;

  // settings used by the directed table
  localparam tube_setting_t SET_AFTER_RESET = '{RST_CYCLES, RST_NUM_COMPOUNDS,
                                                COEF_ONE, COEF_ONE, COEF_ONE, COEF_ONE};
  localparam tube_setting_t SET_FIRST_CYCLE = '{7'd1, 3'd4,
                                                COEF_ONE, 16'd0, 16'hFFFF, 16'd4096};
  localparam tube_setting_t SET_NO_CYCLES   = '{7'd0, 3'd4,
                                                COEF_ONE, 16'd0, 16'hFFFF, 16'd4096};
  localparam tube_setting_t SET_NO_COMPOUND = '{7'd1, 3'd0,
                                                COEF_ONE, 16'd0, 16'hFFFF, 16'd4096};
  localparam tube_setting_t SET_SEVEN_COMP  = '{7'd1, 3'd7,
                                                COEF_ONE, 16'd0, 16'hFFFF, 16'd4096};
  localparam tube_setting_t SET_FIVE_COMP   = '{7'd1, 3'd5,
                                                COEF_ONE, 16'd0, 16'hFFFF, 16'd4096};
  localparam tube_setting_t SET_ZERO_COEFF  = '{7'd8, 3'd4,
                                                16'd0, 16'd0, 16'd0, 16'd0};
  localparam tube_setting_t SET_HUGE_COEFF  = '{7'd8, 3'd4,
                                                16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF};
  localparam tube_setting_t SET_WIDEST      = '{7'd64, 3'd2,
                                                16'hFFFF, 16'd0, COEF_ONE, COEF_ONE};
  localparam tube_setting_t SET_LONGEST     = '{7'd127, 3'd1,
                                                16'd128, COEF_ONE, COEF_ONE, COEF_ONE};
  localparam tube_setting_t SET_MIXED       = '{7'd3, 3'd3,
                                                COEF_ONE, 16'd512, 16'd64, 16'd0};

  // directed table: sums are typed in only where they follow at a glance
  localparam directed_row_t DIRECTED_PLAN [DIRECTED_ROWS] = '{
    // after reset: K = 1, n = 9, every tube well under one half
    '{SET_AFTER_RESET, 6'd0,  1'b1, 3'd0},
    '{SET_AFTER_RESET, 6'd4,  1'b0, 3'd0},
    '{SET_AFTER_RESET, 6'd9,  1'b1, 3'd0},
    '{SET_AFTER_RESET, 6'd10, 1'b1, 3'd0},   // one past the last cycle
    '{SET_AFTER_RESET, 6'd63, 1'b1, 3'd0},
    // a single cycle leaves everything in tube 0
    '{SET_FIRST_CYCLE, 6'd0,  1'b1, 3'd4},
    '{SET_FIRST_CYCLE, 6'd1,  1'b1, 3'd0},
    '{SET_FIRST_CYCLE, 6'd63, 1'b1, 3'd0},
    // no cycles at all
    '{SET_NO_CYCLES,   6'd0,  1'b1, 3'd0},
    // no compounds, and compound counts above the four slots
    '{SET_NO_COMPOUND, 6'd0,  1'b1, 3'd0},
    '{SET_SEVEN_COMP,  6'd0,  1'b1, 3'd4},
    '{SET_FIVE_COMP,   6'd0,  1'b1, 3'd4},
    // zero coefficient: nothing ever moves out of tube 0
    '{SET_ZERO_COEFF,  6'd0,  1'b1, 3'd4},
    '{SET_ZERO_COEFF,  6'd1,  1'b1, 3'd0},
    '{SET_ZERO_COEFF,  6'd7,  1'b1, 3'd0},
    // largest coefficient: almost everything travels to the last tube
    '{SET_HUGE_COEFF,  6'd0,  1'b1, 3'd0},
    '{SET_HUGE_COEFF,  6'd7,  1'b0, 3'd0},
    // the widest run the tube store holds
    '{SET_WIDEST,      6'd63, 1'b0, 3'd0},
    '{SET_WIDEST,      6'd0,  1'b0, 3'd0},
    '{SET_WIDEST,      6'd31, 1'b0, 3'd0},
    // top of the cycle register
    '{SET_LONGEST,     6'd2,  1'b0, 3'd0},
    '{SET_LONGEST,     6'd63, 1'b0, 3'd0},
    // three unlike compounds over a short run
    '{SET_MIXED,       6'd0,  1'b0, 3'd0},
    '{SET_MIXED,       6'd2,  1'b0, 3'd0},
    '{SET_MIXED,       6'd3,  1'b0, 3'd0}
  };

  // ports of the unit, inputs at known values from time zero
  logic                clk_i           = 1'b0;
  logic                rst_ni          = 1'b0;
  logic                cfg_we_i        = 1'b0;
  logic [CFG_AW-1:0]   cfg_addr_i      = '0;
  logic [CFG_DW-1:0]   cfg_wdata_i     = '0;
  logic                s_axis_tvalid_i = 1'b0;
  logic                s_axis_tready_o;
  logic [7:0]          s_axis_tdata_i  = '0;   // tube_number[5:0]
  logic                m_axis_tvalid_o;
  logic                m_axis_tready_i = 1'b0;
  logic [15:0]         m_axis_tdata_o;         // tube_echo[5:0], rounded_sum[8:6]

  // sideband travelling with each offered word: a sum typed into the table
  logic                s_typed_known   = 1'b0;
  logic [SUM_W-1:0]    s_typed_sum     = '0;

  // register copies, as the unit should hold them
  logic [CYC_W-1:0]    mirror_cycles    = RST_CYCLES;
  logic [NCOMP_W-1:0]  mirror_compounds = RST_NUM_COMPOUNDS;
  logic [COEF_W-1:0]   mirror_coeff [COMPOUND_SLOTS] = '{COEF_ONE, COEF_ONE,
                                                         COEF_ONE, COEF_ONE};

  tube_reading_t       pending_readings [$];
  int unsigned         error_count    = 0;
  int unsigned         quiet_cycles   = 0;
  int unsigned         send_idle_pct  = 0;
  int unsigned         recv_stall_pct = 0;
  int unsigned         hold_requests  = 0;

  countercurrent_distribution_tube_unit u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_addr_i      (cfg_addr_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // prediction
  // ---------------------------------------------------------------------------

  // floor(a * b / 2^32), both operands at most 1.0
  function automatic logic [63:0] q32_mul(logic [63:0] a, logic [63:0] b);
    logic [127:0] prod;
    prod = {64'd0, a} * {64'd0, b};
    return prod[95:32];
  endfunction

  // rounded tube content summed over the configured compounds
  function automatic logic [SUM_W-1:0] predict_tube_sum(logic [TUBE_W-1:0] tube);
    logic [63:0]    frac [TUBE_SLOTS];
    logic [63:0]    den;
    logic [63:0]    p_frac;
    logic [63:0]    q_frac;
    logic [SUM_W-1:0] total;
    int unsigned    count;
    int unsigned    last_cycle;
    int unsigned    top;
    total = '0;
    if (mirror_cycles == '0) return total;
    last_cycle = int'(mirror_cycles) - 1;
    if (int'(tube) > last_cycle) return total;
    count = (mirror_compounds > COMPOUND_SLOTS) ? COMPOUND_SLOTS : int'(mirror_compounds);
    for (int i = 0; i < count; i++) begin
      den    = 64'(mirror_coeff[i]) + 64'd256;
      p_frac = (64'(mirror_coeff[i]) << 32) / den;
      q_frac = (64'd1 << 40) / den;
      for (int j = 0; j < TUBE_SLOTS; j++) frac[j] = '0;
      frac[0] = Q32_ONE;
      // one transfer per cycle, only the tubes up to the one asked for
      for (int c = 1; c <= last_cycle; c++) begin
        top = (c < int'(tube)) ? c : int'(tube);
        for (int j = top; j > 0; j--) begin
          frac[j] = q32_mul(frac[j], q_frac) + q32_mul(frac[j-1], p_frac);
        end
        frac[0] = q32_mul(frac[0], q_frac);
      end
      if (frac[tube] >= Q32_HALF) total = total + 1'b1;
    end
    return total;
  endfunction

  function automatic void mirror_write(logic [CFG_AW-1:0] addr, logic [CFG_DW-1:0] data);
    case (addr)
      REG_CYCLES:        mirror_cycles    = data[CYC_W-1:0];
      REG_NUM_COMPOUNDS: mirror_compounds = data[NCOMP_W-1:0];
      REG_COEFF_A:       mirror_coeff[0]  = data[COEF_W-1:0];
      REG_COEFF_B:       mirror_coeff[1]  = data[COEF_W-1:0];
      REG_COEFF_C:       mirror_coeff[2]  = data[COEF_W-1:0];
      REG_COEFF_D:       mirror_coeff[3]  = data[COEF_W-1:0];
      default: ;
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // monitors: values read right after the edge are the ones the unit saw
  // ---------------------------------------------------------------------------

  // register writes and accepted words, predicted at the edge they land on
  always @(posedge clk_i) begin : word_intake
    tube_reading_t entry;
    if (rst_ni) begin
      if (cfg_we_i) mirror_write(cfg_addr_i, cfg_wdata_i);
      if (s_axis_tvalid_i && s_axis_tready_o) begin
        entry.tube = s_axis_tdata_i[TUBE_W-1:0];
        entry.sum  = s_typed_known ? s_typed_sum : predict_tube_sum(entry.tube);
        pending_readings = {pending_readings, entry};
      end
    end
  end

  // result words against the oldest outstanding prediction
  always @(posedge clk_i) begin : reading_check
    tube_reading_t want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (pending_readings.size() == 0) begin
        $display("%0t: result word %h with nothing expected", $time, m_axis_tdata_o);
        error_count++;
      end else begin
        want = pending_readings.pop_front();
        if (m_axis_tdata_o[TUBE_W-1:0] !== want.tube) begin
          $display("%0t: tube_echo expected %0d actual %0d", $time, want.tube,
                   m_axis_tdata_o[TUBE_W-1:0]);
          error_count++;
        end
        if (m_axis_tdata_o[TUBE_W+SUM_W-1:TUBE_W] !== want.sum) begin
          $display("%0t: rounded_sum for tube %0d expected %0d actual %0d", $time,
                   want.tube, want.sum, m_axis_tdata_o[TUBE_W+SUM_W-1:TUBE_W]);
          error_count++;
        end
      end
    end
  end

  // ends the run when nothing has moved for far longer than any word needs
  always @(posedge clk_i) begin : watchdog
    if (!rst_ni || cfg_we_i || (s_axis_tvalid_i && s_axis_tready_o) ||
        (m_axis_tvalid_o && m_axis_tready_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("%0t: no word moved for %0d cycles", $time, quiet_cycles);
      $display("FAIL countercurrent_distribution_tube_unit");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // receiver: random stalls, plus a long hold-off whenever one is requested
  // ---------------------------------------------------------------------------
  initial begin : receiver
    int unsigned holds_done;
    holds_done = 0;
    forever begin
      @(posedge clk_i);
      if (hold_requests != holds_done) begin
        holds_done = hold_requests;
        m_axis_tready_i <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end
      m_axis_tready_i <= !(recv_stall_pct != 0 && $urandom_range(99) < recv_stall_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // sender side
  // ---------------------------------------------------------------------------

  function automatic void set_idle_mode(idle_mode_e mode);
    case (mode)
      IDLE_SENDER:   begin send_idle_pct = 83; recv_stall_pct = 0;  end
      IDLE_RECEIVER: begin send_idle_pct = 0;  recv_stall_pct = 83; end
      IDLE_BOTH:     begin send_idle_pct = 22; recv_stall_pct = 22; end
      default:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
    endcase
  endfunction

  // offer one word and return at the edge it is taken; valid stays high so
  // back-to-back words need no gap
  task automatic offer_tube(input logic [TUBE_W-1:0] tube, input logic known,
                            input logic [SUM_W-1:0] sum);
    if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= {2'b00, tube};
    s_typed_known   <= known;
    s_typed_sum     <= sum;
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
  endtask

  // drop valid and wait until every result has come back
  task automatic settle_unit();
    s_axis_tvalid_i <= 1'b0;
    do @(posedge clk_i); while (pending_readings.size() != 0);
  endtask

  task automatic put_reg(input logic [CFG_AW-1:0] addr, input logic [CFG_DW-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= addr;
    cfg_wdata_i <= data;
    @(posedge clk_i);
  endtask

  // all six registers, junk in the unused upper bits, then the unmapped slots
  task automatic load_setting(input tube_setting_t s);
    put_reg(REG_CYCLES,        {(CFG_DW-CYC_W)'($urandom), s.cycles});
    put_reg(REG_NUM_COMPOUNDS, {(CFG_DW-NCOMP_W)'($urandom), s.compounds});
    put_reg(REG_COEFF_A,       s.coeff_a);
    put_reg(REG_COEFF_B,       s.coeff_b);
    put_reg(REG_COEFF_C,       s.coeff_c);
    put_reg(REG_COEFF_D,       s.coeff_d);
    put_reg(REG_UNMAPPED_A,    CFG_DW'($urandom));
    put_reg(REG_UNMAPPED_B,    CFG_DW'($urandom));
    cfg_we_i <= 1'b0;
  endtask

  // coefficients clustered round the interesting spots: zero, one, huge
  function automatic logic [COEF_W-1:0] pick_coeff();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 10) return '0;
    if (r < 20) return '1;
    if (r < 50) return COEF_W'($urandom_range(511));
    if (r < 75) return COEF_W'($urandom_range(255));
    return COEF_W'($urandom_range(65535, 2048));
  endfunction

  function automatic tube_setting_t draw_setting(setting_kind_e kind);
    tube_setting_t s;
    int unsigned   r;
    s.coeff_a = pick_coeff();
    s.coeff_b = pick_coeff();
    s.coeff_c = pick_coeff();
    s.coeff_d = pick_coeff();
    case (kind)
      KIND_WIDE: begin
        s.cycles    = 7'd64;
        s.compounds = NCOMP_W'($urandom_range(2, 1));
      end
      KIND_LONG: begin
        s.cycles    = 7'd127;
        s.compounds = 3'd1;
      end
      default: begin
        // short runs
        r = $urandom_range(99);
        if (r < 5)       s.cycles = '0;
        else if (r < 10) s.cycles = 7'd1;
        else             s.cycles = CYC_W'($urandom_range(14, 2));
        r = $urandom_range(99);
        if (r < 8)       s.compounds = '0;
        else if (r < 16) s.compounds = NCOMP_W'($urandom_range(7, 5));
        else             s.compounds = NCOMP_W'($urandom_range(4, 1));
      end
    endcase
    return s;
  endfunction

  // mostly tubes the run actually reaches, the rest anywhere
  function automatic logic [TUBE_W-1:0] pick_tube(logic [CYC_W-1:0] cycles);
    if (cycles != '0 && $urandom_range(99) < 75) begin
      if (cycles > TUBE_SLOTS) return TUBE_W'($urandom_range(TUBE_SLOTS - 1));
      return TUBE_W'($urandom_range(int'(cycles) - 1));
    end
    return TUBE_W'($urandom_range(TUBE_SLOTS - 1));
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    tube_setting_t current;
    tube_setting_t drawn;
    setting_kind_e kind;
    int unsigned   words;

    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed table, registers left at reset values until a row asks
    set_idle_mode(IDLE_NONE);
    current = SET_AFTER_RESET;
    for (int r = 0; r < DIRECTED_ROWS; r++) begin
      if (DIRECTED_PLAN[r].setting != current) begin
        settle_unit();
        current = DIRECTED_PLAN[r].setting;
        load_setting(current);
      end
      offer_tube(DIRECTED_PLAN[r].tube, DIRECTED_PLAN[r].known, DIRECTED_PLAN[r].sum);
    end

    // random phases, idling pattern rotating with the phase
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      settle_unit();
      set_idle_mode(idle_mode_e'(ph % 4));
      if (ph == WIDE_PHASE)      kind = KIND_WIDE;
      else if (ph == LONG_PHASE) kind = KIND_LONG;
      else                       kind = KIND_TYPICAL;
      drawn = draw_setting(kind);
      load_setting(drawn);
      // first phase runs with no idling: hold the receiver off so the unit
      // fills up and has to push back on its input
      if (ph == 0) hold_requests <= hold_requests + 1;
      words = (kind == KIND_TYPICAL) ? PHASE_WORDS : SLOW_WORDS;
      for (int i = 0; i < words; i++) begin
        if (kind == KIND_LONG) offer_tube(TUBE_W'($urandom_range(6)), 1'b0, '0);
        else                   offer_tube(pick_tube(drawn.cycles), 1'b0, '0);
      end
    end

    settle_unit();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (error_count == 0) begin
      $display("PASS countercurrent_distribution_tube_unit");
    end else begin
      $display("FAIL countercurrent_distribution_tube_unit");
    end
    $finish;
  end

endmodule
